// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked while out of reset
`define GCNM_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define GCNM_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== rtl/core/gcnm_pkg.sv =====
package gcnm_pkg;

    localparam int MAX_GENES   = 64;
    localparam int EPOW_STAGES = 4;
    localparam int LOG2_STAGES = 16;
    localparam int EXP_STAGES  = 16;
    localparam int WIN_STAGES  = 5;
    // input reg + om^5 + log2 (normalize + squarings) + exp (t, factors, shift) + window
    localparam int LATENCY = 1 + EPOW_STAGES + 1 + LOG2_STAGES + 1 + EXP_STAGES + 1
                             + WIN_STAGES;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        CFG_GENE_LOW   = 2'd0,
        CFG_GENE_HIGH  = 2'd1,
        CFG_MUT_RATE   = 2'd2,
        CFG_TIME_RATIO = 2'd3
    } t_cfg_idx;

    // item context that travels along the pipeline
    typedef struct packed {
        logic               valid;
        logic               mutate;
        logic signed [31:0] gene;
        logic [15:0]        place;
        logic [15:0]        shape;
        logic [16:0]        expo;
    } t_side;

    function automatic logic [63:0] gcnm_isqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bit_w;
        rem   = v;
        res   = '0;
        bit_w = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_w) begin
                rem = rem - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    // 2^-(2^-(idx+1)) in Q0.30, by repeated square roots of one half
    function automatic logic [29:0] gcnm_exp_factor(input int idx);
        logic [63:0] c;
        c = 64'd1 << 29;
        for (int i = 0; i <= idx; i++) begin
            c = gcnm_isqrt(c << 30);
        end
        return c[29:0];
    endfunction

endpackage

// ===== rtl/core/gene_crossover_nonuniform_mutate_unit.sv =====
// channel   direction  handshake                    payload
// item in   input      start high, busy low         gene_index, cut_point, parents, randoms
// result    output     o_valid strobe, one cycle    child_gene, was_mutated
// config    input      i_cfg_valid and o_cfg_ready  i_cfg_index, i_cfg_data
//
// one item per cycle
// latency is set by the log2 squaring chain and the 2^-t factor chain, one multiply a stage
// busy and o_cfg_ready are constant, the pipeline never stalls
// synchronous active low reset clears all valid bits and loads register defaults
module gene_crossover_nonuniform_mutate_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [5:0]         i_gene_index,
    input  logic [6:0]         i_cut_point,
    input  logic signed [31:0] i_parent_a_gene,
    input  logic signed [31:0] i_parent_b_gene,
    input  logic [15:0]        i_r_apply,
    input  logic [15:0]        i_r_shape,
    input  logic [15:0]        i_r_place,
    output logic               o_valid,
    output logic signed [31:0] o_child_gene,
    output logic               o_was_mutated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  gcnm_pkg::t_cfg_idx i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import gcnm_pkg::*;

    logic signed [31:0] r_gene_low;
    logic signed [31:0] r_gene_high;
    logic [16:0]        r_mut_rate;
    logic [16:0]        r_time_ratio;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gene_low   <= '0;
            r_gene_high  <= 32'sh0001_0000;
            r_mut_rate   <= '0;
            r_time_ratio <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GENE_LOW:   r_gene_low   <= i_cfg_data;
                CFG_GENE_HIGH:  r_gene_high  <= i_cfg_data;
                CFG_MUT_RATE:   r_mut_rate   <= i_cfg_data[16:0];
                CFG_TIME_RATIO: r_time_ratio <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // input stage: crossover and mutation decision
    t_side       n_side;
    logic [6:0]  n_cut;
    logic [16:0] n_mu;
    t_side       r_side [EPOW_STAGES+1];
    logic [16:0] r_om   [EPOW_STAGES+1];

    always_comb begin
        n_cut  = (i_cut_point > 7'(MAX_GENES)) ? 7'(MAX_GENES) : i_cut_point;
        n_mu   = (r_time_ratio > ONE_Q16) ? ONE_Q16 : r_time_ratio;
        n_side.valid  = start && !busy;
        n_side.mutate = {1'b0, i_r_apply} < r_mut_rate;
        n_side.gene   = ({1'b0, i_gene_index} > n_cut) ? i_parent_b_gene : i_parent_a_gene;
        n_side.place  = i_r_place;
        n_side.shape  = i_r_shape;
        n_side.expo   = ONE_Q16 - n_mu;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_side[0].valid <= 1'b0;
        else          r_side[0] <= n_side;
        r_om[0] <= ONE_Q16 - n_mu;
    end

    // exponent (1-mu)^5, one multiply a stage
    for (genvar s = 0; s < EPOW_STAGES; s++) begin : g_epow
        logic [33:0] n_ep;
        t_side       n_sd;
        always_comb begin
            n_ep      = 34'(r_side[s].expo) * 34'(r_om[s]);
            n_sd      = r_side[s];
            n_sd.expo = n_ep[32:16];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_side[s+1].valid <= 1'b0;
            else          r_side[s+1] <= n_sd;
            r_om[s+1] <= r_om[s];
        end
    end

    t_side       w_lside;
    logic [19:0] w_log;
    t_side       w_eside;
    logic [16:0] w_pw;

    gcnm_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_side[EPOW_STAGES]),
        .o_side  (w_lside),
        .o_log   (w_log)
    );

    gcnm_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (w_lside),
        .i_log   (w_log),
        .o_side  (w_eside),
        .o_pw    (w_pw)
    );

    gcnm_window u_window (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_side        (w_eside),
        .i_pw          (w_pw),
        .i_gene_low    (r_gene_low),
        .i_gene_high   (r_gene_high),
        .o_valid       (o_valid),
        .o_child_gene  (o_child_gene),
        .o_was_mutated (o_was_mutated)
    );

endmodule

// ===== rtl/core/gcnm_log2.sv =====
module gcnm_log2 (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gcnm_pkg::t_side i_side,
    output gcnm_pkg::t_side o_side,
    output logic [19:0]    o_log
);
    import gcnm_pkg::*;

    t_side       r_side [LOG2_STAGES+1];
    logic [30:0] r_m    [LOG2_STAGES+1];
    logic [15:0] r_frac [LOG2_STAGES+1];
    logic [3:0]  r_k    [LOG2_STAGES+1];

    logic [3:0]  n_k;
    logic [30:0] n_m;

    // top bit index and Q1.30 mantissa
    always_comb begin
        n_k = '0;
        for (int b = 1; b < 16; b++) begin
            if (i_side.shape[b]) n_k = 4'(b);
        end
        n_m = 31'(i_side.shape) << (5'd30 - {1'b0, n_k});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0].valid <= 1'b0;
        end else begin
            r_side[0] <= i_side;
        end
        r_m[0]    <= n_m;
        r_frac[0] <= '0;
        r_k[0]    <= n_k;
    end

    for (genvar s = 0; s < LOG2_STAGES; s++) begin : g_sq
        logic [61:0] n_sq;
        logic [30:0] n_mn;
        logic [15:0] n_fr;
        always_comb begin
            n_sq = 62'(r_m[s]) * 62'(r_m[s]);
            n_fr = r_frac[s];
            if (n_sq[61]) begin
                n_mn = n_sq[61:31];
                n_fr[LOG2_STAGES-1-s] = 1'b1;
            end else begin
                n_mn = n_sq[60:30];
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s+1].valid <= 1'b0;
            end else begin
                r_side[s+1] <= r_side[s];
            end
            r_m[s+1]    <= n_mn;
            r_frac[s+1] <= n_fr;
            r_k[s+1]    <= r_k[s];
        end
    end

    assign o_side = r_side[LOG2_STAGES];
    assign o_log  = {r_k[LOG2_STAGES], r_frac[LOG2_STAGES]};

endmodule

// ===== rtl/core/gcnm_exp2.sv =====
module gcnm_exp2 (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  gcnm_pkg::t_side i_side,
    input  logic [19:0]     i_log,
    output gcnm_pkg::t_side o_side,
    output logic [16:0]     o_pw
);
    import gcnm_pkg::*;

    t_side       r_side [EXP_STAGES+1];
    logic [20:0] r_t    [EXP_STAGES+1];
    logic [30:0] r_res  [EXP_STAGES+1];
    t_side       r_oside;
    logic [16:0] r_pw;

    logic [20:0] n_nl;
    logic [37:0] n_tp;

    always_comb begin
        n_nl = 21'h100000 - {1'b0, i_log};
        n_tp = 38'(n_nl) * 38'(i_side.expo);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0].valid <= 1'b0;
        end else begin
            r_side[0] <= i_side;
        end
        r_t[0]   <= n_tp[36:16];
        r_res[0] <= 31'h4000_0000;
    end

    for (genvar s = 0; s < EXP_STAGES; s++) begin : g_fac
        localparam logic [29:0] FAC = gcnm_exp_factor(s);
        logic [60:0] n_prod;
        logic [30:0] n_res;
        always_comb begin
            n_prod = 61'(r_res[s]) * 61'(FAC);
            n_res  = r_t[s][EXP_STAGES-1-s] ? n_prod[60:30] : r_res[s];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s+1].valid <= 1'b0;
            end else begin
                r_side[s+1] <= r_side[s];
            end
            r_t[s+1]   <= r_t[s];
            r_res[s+1] <= n_res;
        end
    end

    logic [4:0]  n_ti;
    logic [30:0] n_sh;
    logic [16:0] n_pw;

    always_comb begin
        n_ti = r_t[EXP_STAGES][20:16];
        n_sh = (n_ti == 5'd31) ? '0 : (r_res[EXP_STAGES] >> n_ti);
        if (r_side[EXP_STAGES].expo == '0) begin
            n_pw = ONE_Q16;
        end else if (r_side[EXP_STAGES].shape == '0) begin
            n_pw = '0;
        end else begin
            n_pw = n_sh[30:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oside.valid <= 1'b0;
        end else begin
            r_oside <= r_side[EXP_STAGES];
        end
        r_pw <= n_pw;
    end

    assign o_side = r_oside;
    assign o_pw   = r_pw;

endmodule

// ===== rtl/core/gcnm_window.sv =====
module gcnm_window (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gcnm_pkg::t_side    i_side,
    input  logic [16:0]        i_pw,
    input  logic signed [31:0] i_gene_low,
    input  logic signed [31:0] i_gene_high,
    output logic               o_valid,
    output logic signed [31:0] o_child_gene,
    output logic               o_was_mutated
);
    import gcnm_pkg::*;

    // stage 1: window half width
    t_side       r1_side;
    logic [31:0] r1_delta;
    logic [16:0] n_d;
    logic [32:0] n_span;
    logic [48:0] n_dprod;

    always_comb begin
        n_d     = ONE_Q16 - i_pw;
        n_span  = (i_gene_high > i_gene_low) ?
                  33'(34'(i_gene_high) - 34'(i_gene_low)) : '0;
        n_dprod = 49'(n_span[31:0]) * 49'(n_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_side.valid <= 1'b0;
        else          r1_side <= i_side;
        r1_delta <= n_dprod[47:16];
    end

    // stage 2: clamp window to bounds
    t_side              r2_side;
    logic signed [31:0] r2_hi;
    logic signed [31:0] r2_lo;
    logic signed [33:0] n_hi;
    logic signed [33:0] n_lo;

    always_comb begin
        n_hi = 34'(r1_side.gene) + $signed({2'b00, r1_delta});
        n_lo = 34'(r1_side.gene) - $signed({2'b00, r1_delta});
        if (n_hi > 34'(i_gene_high)) n_hi = 34'(i_gene_high);
        if (n_lo < 34'(i_gene_low))  n_lo = 34'(i_gene_low);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_side.valid <= 1'b0;
        else          r2_side <= r1_side;
        r2_hi <= n_hi[31:0];
        r2_lo <= n_lo[31:0];
    end

    // stage 3: window width, may be negative for an out of bounds gene
    t_side              r3_side;
    logic signed [31:0] r3_lo;
    logic signed [32:0] r3_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_side.valid <= 1'b0;
        else          r3_side <= r2_side;
        r3_lo   <= r2_lo;
        r3_diff <= 33'(r2_hi) - 33'(r2_lo);
    end

    // stage 4: placement product
    t_side              r4_side;
    logic signed [31:0] r4_lo;
    logic signed [49:0] r4_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_side.valid <= 1'b0;
        else          r4_side <= r3_side;
        r4_lo   <= r3_lo;
        r4_prod <= 50'(r3_diff) * $signed({34'd0, r3_side.place});
    end

    // stage 5: divide by 65536 toward zero, pick result
    logic               r_valid;
    logic signed [31:0] r_child;
    logic               r_mut;
    logic [49:0]        n_mag;
    logic signed [49:0] n_q;
    logic signed [31:0] n_new;

    always_comb begin
        if (r4_prod < 0) begin
            n_mag = 50'(-r4_prod) >> 16;
            n_q   = -$signed(n_mag);
        end else begin
            n_mag = 50'(r4_prod) >> 16;
            n_q   = $signed(n_mag);
        end
        n_new = r4_lo + n_q[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= r4_side.valid;
        r_child <= r4_side.mutate ? n_new : r4_side.gene;
        r_mut   <= r4_side.mutate;
    end

    assign o_valid       = r_valid;
    assign o_child_gene  = r_child;
    assign o_was_mutated = r_mut;

endmodule

// ===== rtl/core/gcnm_checker.sv =====
`include "assert_macros.svh"

module gcnm_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [5:0]         i_gene_index,
    input logic [6:0]         i_cut_point,
    input logic signed [31:0] i_parent_a_gene,
    input logic signed [31:0] i_parent_b_gene,
    input logic               o_valid,
    input logic signed [31:0] o_child_gene,
    input logic               o_was_mutated,
    input logic               o_cfg_ready
);
    import gcnm_pkg::*;

    // every taken item comes out after the fixed latency
    `GCNM_CHECK(a_item_out, (start && !busy) |-> ##LATENCY o_valid, "item lost in pipeline")

    // no result without an item taken a latency earlier
    `GCNM_CHECK(a_no_extra, o_valid |-> $past(start && !busy, LATENCY), "spurious result")

    // an unmutated child is the crossed-over parent gene
    `GCNM_CHECK(a_cross, (o_valid && !o_was_mutated) |-> (o_child_gene == $past((i_gene_index > i_cut_point) ? i_parent_b_gene : i_parent_a_gene, LATENCY)), "crossover mismatch")

    // streaming unit never refuses an item or a register write
    `GCNM_ALWAYS(a_open, (!busy && o_cfg_ready), "unit stalled")

endmodule

bind gene_crossover_nonuniform_mutate_unit gcnm_checker u_gcnm_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import gcnm_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [5:0]         idx;
        logic [6:0]         cut;
        logic signed [31:0] gene_a;
        logic signed [31:0] gene_b;
        logic [15:0]        r_apply;
        logic [15:0]        r_shape;
        logic [15:0]        r_place;
    } t_gene_item;

    typedef struct {
        logic signed [31:0] gene;
        logic               mutated;
    } t_child;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [5:0]         i_gene_index = '0;
    logic [6:0]         i_cut_point = '0;
    logic signed [31:0] i_parent_a_gene = '0;
    logic signed [31:0] i_parent_b_gene = '0;
    logic [15:0]        i_r_apply = '0;
    logic [15:0]        i_r_shape = '0;
    logic [15:0]        i_r_place = '0;
    logic               o_valid;
    logic signed [31:0] o_child_gene;
    logic               o_was_mutated;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    t_cfg_idx           i_cfg_index = CFG_GENE_LOW;
    logic [31:0]        i_cfg_data = '0;

    // shadow copy of the block's registers
    longint             shadow_low = 0;
    longint             shadow_high = 65536;
    logic [16:0]        shadow_rate = '0;
    logic [16:0]        shadow_time = '0;

    t_child             pending_children[$];
    int                 error_count = 0;
    bit                 gaps_on = 1'b1;

    gene_crossover_nonuniform_mutate_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_gene_index    (i_gene_index),
        .i_cut_point     (i_cut_point),
        .i_parent_a_gene (i_parent_a_gene),
        .i_parent_b_gene (i_parent_b_gene),
        .i_r_apply       (i_r_apply),
        .i_r_shape       (i_r_shape),
        .i_r_place       (i_r_place),
        .o_valid         (o_valid),
        .o_child_gene    (o_child_gene),
        .o_was_mutated   (o_was_mutated),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned root;
        longint unsigned bw;
        root = 0;
        bw = 64'd1 << 62;
        while (bw > v) bw = bw >> 2;
        while (bw != 0) begin
            if (v >= root + bw) begin
                v = v - (root + bw);
                root = (root >> 1) + bw;
            end else begin
                root = root >> 1;
            end
            bw = bw >> 2;
        end
        return root;
    endfunction

    // log2 in Q16.16 for r in 1..65535
    function automatic longint unsigned log2_fix(input longint unsigned r);
        int              k;
        longint unsigned mant;
        longint unsigned frac;
        k = 0;
        frac = 0;
        while (k < 15 && (r >> (k + 1)) != 0) k++;
        mant = r << (30 - k);
        for (int i = 0; i < 16; i++) begin
            mant = (mant * mant) >> 30;
            if (mant >= (64'd1 << 31)) begin
                mant = mant >> 1;
                frac = frac | (64'd1 << (15 - i));
            end
        end
        return (longint'(k) << 16) | frac;
    endfunction

    // 2^-t, t in Q16.16, result Q0.30
    function automatic longint unsigned exp2_neg(input longint unsigned t);
        longint unsigned whole;
        longint unsigned acc;
        longint unsigned factor;
        whole = t >> 16;
        acc = 64'd1 << 30;
        factor = 64'd1 << 29;
        for (int i = 0; i < 16; i++) begin
            factor = int_sqrt(factor << 30);
            if (t[15 - i]) acc = (acc * factor) >> 30;
        end
        if (whole >= 31) return 0;
        return acc >> whole;
    endfunction

    function automatic longint unsigned shape_power(input longint unsigned r,
                                                    input longint unsigned e);
        longint unsigned nl;
        if (e == 0) return 65536;
        if (r == 0) return 0;
        nl = (64'd16 << 16) - log2_fix(r);
        return exp2_neg((nl * e) >> 16) >> 14;
    endfunction

    function automatic t_child breed_child(input t_gene_item it);
        t_child          res;
        longint          g;
        longint unsigned cut;
        longint unsigned om;
        longint unsigned e;
        longint unsigned span;
        longint unsigned d;
        longint          delta;
        longint          hi;
        longint          lo;
        cut = (it.cut > MAX_GENES) ? MAX_GENES : it.cut;
        g = (it.idx > cut) ? longint'(it.gene_b) : longint'(it.gene_a);
        res.mutated = 1'b0;
        if (it.r_apply < shadow_rate) begin
            om = 65536 - ((shadow_time > 65536) ? 65536 : shadow_time);
            e = om;
            for (int i = 0; i < 4; i++) e = (e * om) >> 16;
            d = 65536 - shape_power(it.r_shape, e);
            span = (shadow_high > shadow_low) ? longint'(shadow_high - shadow_low) : 0;
            delta = longint'((span * d) >> 16);
            hi = g + delta;
            if (hi > shadow_high) hi = shadow_high;
            lo = g - delta;
            if (lo < shadow_low) lo = shadow_low;
            g = lo + ((hi - lo) * longint'(it.r_place)) / 65536;
            res.mutated = 1'b1;
        end
        res.gene = g[31:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        error_count++;
        $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
    endtask

    always @(posedge i_clk) begin
        t_child want;
        if (i_rst_n && o_valid) begin
            if (pending_children.size() == 0) begin
                report_mismatch("unexpected child", 0, o_child_gene);
            end else begin
                want = pending_children.pop_front();
                if (o_child_gene !== want.gene)
                    report_mismatch("child_gene", want.gene, o_child_gene);
                if (o_was_mutated !== want.mutated)
                    report_mismatch("was_mutated", want.mutated, o_was_mutated);
            end
        end
    end

    initial begin
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("gene_crossover_nonuniform_mutate_unit test failed");
        $finish;
    end

    task automatic send_gene(input t_gene_item it);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_gene_index    <= it.idx;
        i_cut_point     <= it.cut;
        i_parent_a_gene <= it.gene_a;
        i_parent_b_gene <= it.gene_b;
        i_r_apply       <= it.r_apply;
        i_r_shape       <= it.r_shape;
        i_r_place       <= it.r_place;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_children.push_back(breed_child(it));
    endtask

    // drain the pipeline, then write one register
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        start <= 1'b0;
        while (pending_children.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_GENE_LOW:   shadow_low = longint'($signed(value));
            CFG_GENE_HIGH:  shadow_high = longint'($signed(value));
            CFG_MUT_RATE:   shadow_rate = value[16:0];
            CFG_TIME_RATIO: shadow_time = value[16:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [16:0] rate, input logic [16:0] tr);
        write_reg(CFG_GENE_LOW, lo);
        write_reg(CFG_GENE_HIGH, hi);
        write_reg(CFG_MUT_RATE, {15'd0, rate});
        write_reg(CFG_TIME_RATIO, {15'd0, tr});
    endtask

    function automatic t_gene_item rand_item();
        t_gene_item it;
        longint     span;
        it.idx = 6'($urandom_range(0, 63));
        it.cut = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(65, 127))
                                             : 7'($urandom_range(0, 64));
        span = shadow_high - shadow_low;
        if (span > 0 && $urandom_range(0, 2) != 0) begin
            // mostly genes around the bounds window
            it.gene_a = 32'(shadow_low + longint'({$urandom, $urandom} % (span + 3)) - 1);
            it.gene_b = 32'(shadow_low + longint'({$urandom, $urandom} % (span + 3)) - 1);
        end else begin
            it.gene_a = $urandom;
            it.gene_b = $urandom;
        end
        it.r_apply = 16'($urandom);
        it.r_shape = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom);
        it.r_place = 16'($urandom);
        return it;
    endfunction

    function automatic t_gene_item make_item(input logic [5:0] idx, input logic [6:0] cut,
                                             input logic [31:0] a, input logic [31:0] b,
                                             input logic [15:0] ra, input logic [15:0] rs,
                                             input logic [15:0] rp);
        t_gene_item it;
        it.idx = idx; it.cut = cut; it.gene_a = a; it.gene_b = b;
        it.r_apply = ra; it.r_shape = rs; it.r_place = rp;
        return it;
    endfunction

    task automatic test_crossover();
        // reset defaults: rate zero, nothing mutates
        send_gene(make_item(6'd0, 7'd0, 32'h7fffffff, 32'h80000000, 16'd0, 16'd0, 16'd0));
        send_gene(make_item(6'd1, 7'd0, 32'h12345678, 32'hdeadbeef, 16'hffff, 16'hffff,
                            16'hffff));
        send_gene(make_item(6'd63, 7'd63, 32'h80000000, 32'h7fffffff, 16'd0, 16'd1, 16'd1));
        send_gene(make_item(6'd63, 7'd62, 32'h00000001, 32'hffffffff, 16'd5, 16'd5, 16'd5));
        send_gene(make_item(6'd63, 7'd64, 32'haaaaaaaa, 32'h55555555, 16'd0, 16'd0, 16'd0));
        send_gene(make_item(6'd63, 7'd127, 32'h55555555, 32'haaaaaaaa, 16'd0, 16'd0, 16'd0));
        send_gene(make_item(6'd32, 7'd31, 32'h0000ffff, 32'hffff0000, 16'd0, 16'd0, 16'd0));
    endtask

    task automatic test_mutation_corners();
        set_config(32'd0, 32'd65536, 17'd65536, 17'd0);
        send_gene(make_item(6'd0, 7'd10, 32'd32768, 32'd0, 16'd0, 16'd0, 16'd0));
        send_gene(make_item(6'd0, 7'd10, 32'd32768, 32'd0, 16'hffff, 16'd1, 16'hffff));
        send_gene(make_item(6'd20, 7'd10, 32'd0, 32'd65536, 16'd100, 16'hffff, 16'h8000));
        send_gene(make_item(6'd20, 7'd10, 32'd0, 32'h7fffffff, 16'd100, 16'h4000, 16'd1));
        send_gene(make_item(6'd5, 7'd10, 32'h80000000, 32'd0, 16'd7, 16'h1234, 16'hffff));
        // rate and time ratio above one
        set_config(32'h80000000, 32'h7fffffff, 17'h1ffff, 17'h1ffff);
        send_gene(make_item(6'd1, 7'd2, 32'd0, 32'd0, 16'hffff, 16'h8000, 16'h8000));
        send_gene(make_item(6'd9, 7'd2, 32'h80000000, 32'h7fffffff, 16'hffff, 16'd0,
                            16'hffff));
        write_reg(CFG_TIME_RATIO, 32'd32768);
        send_gene(make_item(6'd9, 7'd2, 32'd0, 32'h7fffffff, 16'd0, 16'd1, 16'hffff));
        send_gene(make_item(6'd1, 7'd2, 32'h80000000, 32'd0, 16'd0, 16'hffff, 16'd0));
        // inverted bounds give an empty span
        set_config(32'd1000, 32'hfffff000, 17'd65536, 17'd100);
        send_gene(make_item(6'd3, 7'd3, 32'd5, 32'd0, 16'd0, 16'h0100, 16'h8000));
        send_gene(make_item(6'd4, 7'd3, 32'd5, 32'hfff00000, 16'd0, 16'h0100, 16'hffff));
        // gene outside bounds: inverted window
        set_config(32'd65536, 32'd131072, 17'd65536, 17'd60000);
        send_gene(make_item(6'd0, 7'd1, 32'h7fffffff, 32'd0, 16'd0, 16'h0010, 16'hffff));
        send_gene(make_item(6'd0, 7'd1, 32'h80000000, 32'd0, 16'd0, 16'hfff0, 16'hc000));
        send_gene(make_item(6'd0, 7'd1, 32'd0, 32'd0, 16'd0, 16'd1, 16'd1));
    endtask

    task automatic test_random_stream();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [16:0] rate;
        logic [16:0] tr;
        for (int phase = 0; phase < 8; phase++) begin
            lo = $urandom;
            case ($urandom_range(0, 3))
                0: hi = lo + $urandom_range(0, 1 << 20);
                1: hi = $urandom;
                2: begin lo = 32'h80000000; hi = 32'h7fffffff; end
                default: begin lo = 32'hfffe0000; hi = 32'h00020000; end
            endcase
            case ($urandom_range(0, 3))
                0: rate = 17'd65536;
                1: rate = 17'h1ffff;
                2: rate = 17'd0;
                default: rate = 17'($urandom_range(0, 65536));
            endcase
            case ($urandom_range(0, 3))
                0: tr = 17'd0;
                1: tr = 17'h1ffff;
                2: tr = 17'd65536;
                default: tr = 17'($urandom_range(0, 65536));
            endcase
            set_config(lo, hi, rate, tr);
            // last stretch runs back to back
            gaps_on = (phase < 6);
            for (int n = 0; n < 75; n++) send_gene(rand_item());
        end
        start <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_crossover();
        test_mutation_corners();
        test_random_stream();
        while (pending_children.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0)
            $display("gene_crossover_nonuniform_mutate_unit test passed");
        else
            $display("gene_crossover_nonuniform_mutate_unit test failed");
        $finish;
    end

endmodule
